// File: rtl/core/multi_queue_packet_handle_manager_unit_defines.svh
// assertion helpers for the packet handle manager
`ifndef MULTI_QUEUE_PACKET_HANDLE_MANAGER_UNIT_DEFINES_SVH
`define MULTI_QUEUE_PACKET_HANDLE_MANAGER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clock, quiet during reset
`define MQPH_CHECK(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MQPH_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/mqph_pkg.sv
`timescale 1ns / 1ps

package mqph_pkg;

   localparam int HANDLE_W       = 16;
   localparam int QUEUE_IDX_BITS = 6;
   localparam int FCOUNT_BITS    = 13;
   localparam int ACTIVE_BITS    = 5;
   localparam int OP_QUEUE_DEPTH = 2;
   localparam int OP_PTR_BITS    = (OP_QUEUE_DEPTH > 1) ? $clog2(OP_QUEUE_DEPTH) : 1;

   localparam int DEF_NUM_QUEUES  = 16;
   localparam int DEF_NUM_SLOTS   = 16;
   localparam int DEF_STORE_DEPTH = 64;
   localparam int DEF_HANDLE_BITS = 16;

   localparam logic [ACTIVE_BITS-1:0] ACTIVE_QUEUES_RESET = 5'd16;

   localparam logic [1:0] FUNC_QUERY   = 2'd0;
   localparam logic [1:0] FUNC_ENQUEUE = 2'd1;
   localparam logic [1:0] FUNC_DEQUEUE = 2'd2;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_BAD_SLOT   = 3'd1,
      STATUS_BAD_QUEUE  = 3'd2,
      STATUS_SLOT_EMPTY = 3'd3,
      STATUS_FULL       = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      K_NOP   = 3'd0,
      K_QUERY = 3'd1,
      K_ENQ   = 3'd2,
      K_DEQ   = 3'd3,
      K_ERROR = 3'd4
   } op_kind_type;

   // classified request as it travels from front to back
   typedef struct packed {
      op_kind_type                kind;
      status_type                 status;
      logic [QUEUE_IDX_BITS-1:0]  queue;
      logic                       occupied;
      logic [HANDLE_W-1:0]        handle;
   } op_type;

   typedef struct packed {
      logic [FCOUNT_BITS-1:0] free_count;
      logic [FCOUNT_BITS-1:0] low_mark;
   } back_status_type;

endpackage

// File: rtl/core/mqph_if.sv
`timescale 1ns / 1ps

interface mqph_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [7:0]  queue_number;
   logic [7:0]  slot_number;
   logic        slot_occupied;
   logic [15:0] slot_handle;

   modport source (output valid, output func, output queue_number, output slot_number,
                   output slot_occupied, output slot_handle, input ready);
   modport sink   (input valid, input func, input queue_number, input slot_number,
                   input slot_occupied, input slot_handle, output ready);
endinterface

interface mqph_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        queue_is_empty;
   logic        new_slot_occupied;
   logic [15:0] new_slot_handle;
   logic        freed_valid;
   logic [15:0] freed_handle;

   modport source (output valid, output status, output queue_is_empty,
                   output new_slot_occupied, output new_slot_handle,
                   output freed_valid, output freed_handle, input ready);
   modport sink   (input valid, input status, input queue_is_empty,
                   input new_slot_occupied, input new_slot_handle,
                   input freed_valid, input freed_handle, output ready);
endinterface

// File: rtl/core/mqph_front.sv
`timescale 1ns / 1ps

module mqph_front #(
   parameter int NUM_QUEUES  = mqph_pkg::DEF_NUM_QUEUES,
   parameter int NUM_SLOTS   = mqph_pkg::DEF_NUM_SLOTS,
   parameter int HANDLE_BITS = mqph_pkg::DEF_HANDLE_BITS
) (
   mqph_req_if.sink                          req,
   input  logic [mqph_pkg::ACTIVE_BITS-1:0]  active_queues,
   input  logic                              opq_full,
   output logic                              opq_push,
   output mqph_pkg::op_type                  opq_op
);
   import mqph_pkg::*;

   localparam logic [7:0] QUEUE_LIMIT = 8'(NUM_QUEUES);
   localparam logic [8:0] SLOT_LIMIT  = 9'(NUM_SLOTS);
   localparam logic [HANDLE_W-1:0] HANDLE_MASK =
      (HANDLE_BITS >= HANDLE_W) ? {HANDLE_W{1'b1}} : HANDLE_W'((32'd1 << HANDLE_BITS) - 32'd1);

   logic queue_ok;
   logic slot_ok;

   assign queue_ok = (req.queue_number < {3'b000, active_queues}) &&
                     (req.queue_number < QUEUE_LIMIT);
   assign slot_ok  = {1'b0, req.slot_number} < SLOT_LIMIT;

   assign req.ready = !opq_full;
   assign opq_push  = req.valid && !opq_full;

   always_comb begin
      opq_op.kind     = K_NOP;
      opq_op.status   = STATUS_OK;
      opq_op.queue    = req.queue_number[QUEUE_IDX_BITS-1:0];
      opq_op.occupied = req.slot_occupied;
      // an empty slot carries a zero handle everywhere downstream
      opq_op.handle   = req.slot_occupied ? (req.slot_handle & HANDLE_MASK) : '0;
      unique case (req.func)
         FUNC_QUERY: begin
            if (queue_ok) begin
               opq_op.kind = K_QUERY;
            end else begin
               opq_op.kind   = K_ERROR;
               opq_op.status = STATUS_BAD_QUEUE;
            end
         end
         FUNC_ENQUEUE, FUNC_DEQUEUE: begin
            if (!slot_ok) begin
               opq_op.kind   = K_ERROR;
               opq_op.status = STATUS_BAD_SLOT;
            end else if (!queue_ok) begin
               opq_op.kind   = K_ERROR;
               opq_op.status = STATUS_BAD_QUEUE;
            end else if (req.func == FUNC_ENQUEUE && !req.slot_occupied) begin
               opq_op.kind   = K_ERROR;
               opq_op.status = STATUS_SLOT_EMPTY;
            end else begin
               opq_op.kind = (req.func == FUNC_ENQUEUE) ? K_ENQ : K_DEQ;
            end
         end
         default: begin
            opq_op.kind = K_NOP;
         end
      endcase
   end

endmodule

// File: rtl/core/mqph_opq.sv
`timescale 1ns / 1ps

module mqph_opq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mqph_pkg::op_type  push_op,
   output logic              full,
   input  logic              pop,
   output mqph_pkg::op_type  pop_op,
   output logic              empty
);
   import mqph_pkg::*;

   localparam logic [OP_PTR_BITS-1:0] LAST_PTR  = OP_PTR_BITS'(OP_QUEUE_DEPTH - 1);
   localparam logic [OP_PTR_BITS:0]   FULL_CNT  = (OP_PTR_BITS + 1)'(OP_QUEUE_DEPTH);

   op_type                 entry_ff [OP_QUEUE_DEPTH];
   logic [OP_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OP_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OP_PTR_BITS:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full    = count_ff == FULL_CNT;
   assign empty   = count_ff == '0;
   assign pop_op  = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// File: rtl/core/mqph_back.sv
`timescale 1ns / 1ps

module mqph_back #(
   parameter int NUM_QUEUES  = mqph_pkg::DEF_NUM_QUEUES,
   parameter int STORE_DEPTH = mqph_pkg::DEF_STORE_DEPTH,
   parameter int HANDLE_BITS = mqph_pkg::DEF_HANDLE_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      opq_empty,
   input  mqph_pkg::op_type          opq_op,
   output logic                      opq_pop,
   mqph_rsp_if.source                rsp,
   output mqph_pkg::back_status_type stat
);
   import mqph_pkg::*;

   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = AW + 1;
   localparam int SB = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
   localparam logic [CW-1:0] DEPTH_COUNT = CW'(STORE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EVAL = 3'b010,
      ST_DEQ  = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;
   op_type         op_ff;

   logic [CW-1:0]         free_count_ff, free_count_in;
   logic [CW-1:0]         low_mark_ff, low_mark_in;
   logic [NUM_QUEUES-1:0] qvalid_ff, qvalid_in;

   // per-queue tables
   logic [AW-1:0] head_mem [NUM_QUEUES];
   logic [AW-1:0] tail_mem [NUM_QUEUES];
   logic [CW-1:0] len_mem  [NUM_QUEUES];
   // shared store and free stack
   logic [AW-1:0] link_mem   [STORE_DEPTH];
   logic [SB-1:0] entry_mem  [STORE_DEPTH];
   logic [AW-1:0] fstack_mem [STORE_DEPTH];

   logic [AW-1:0] head_rd_ff, tail_rd_ff, fs_rd_ff, link_rd_ff;
   logic [CW-1:0] len_rd_ff;
   logic [SB-1:0] entry_rd_ff;
   logic          qvalid_rd_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic                rsp_qempty_ff, rsp_qempty_in;
   logic                rsp_nocc_ff, rsp_nocc_in;
   logic [HANDLE_W-1:0] rsp_nh_ff, rsp_nh_in;
   logic                rsp_fv_ff, rsp_fv_in;
   logic [HANDLE_W-1:0] rsp_fh_ff, rsp_fh_in;

   logic [QW-1:0] qidx;
   logic [CW-1:0] len_cur;
   logic          len_zero;
   logic          out_free;
   logic          store_full;
   logic [AW-1:0] fresh_entry;
   logic          go_deq;
   logic          finish_eval;
   logic          finish_deq;
   logic          finish;
   logic          enq_do;
   logic          push_free;

   assign qidx       = op_ff.queue[QW-1:0];
   assign len_cur    = qvalid_rd_ff ? len_rd_ff : '0;
   assign len_zero   = len_cur == '0;
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign store_full = free_count_ff == '0;
   // stack slots below the low mark were never pushed and still hold their own index
   assign fresh_entry = (free_count_ff == low_mark_ff) ? AW'(free_count_ff - CW'(1)) : fs_rd_ff;

   assign opq_pop     = (state_ff == ST_IDLE) && !opq_empty;
   assign go_deq      = (state_ff == ST_EVAL) && (op_ff.kind == K_DEQ) && !len_zero;
   assign finish_eval = (state_ff == ST_EVAL) && !go_deq && out_free;
   assign finish_deq  = (state_ff == ST_DEQ) && out_free;
   assign finish      = finish_eval || finish_deq;
   assign enq_do      = finish_eval && (op_ff.kind == K_ENQ) && !store_full;
   assign push_free   = finish_deq && (free_count_ff < DEPTH_COUNT);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (opq_pop) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (go_deq) begin
               state_in = ST_DEQ;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DEQ: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      free_count_in = free_count_ff;
      low_mark_in   = low_mark_ff;
      qvalid_in     = qvalid_ff;
      if (enq_do) begin
         free_count_in    = free_count_ff - CW'(1);
         qvalid_in[qidx]  = 1'b1;
         if (free_count_ff == low_mark_ff) begin
            low_mark_in = free_count_ff - CW'(1);
         end
      end else if (push_free) begin
         free_count_in = free_count_ff + CW'(1);
      end
   end

   // result for the item in flight
   always_comb begin
      rsp_status_in = op_ff.status;
      rsp_qempty_in = 1'b0;
      rsp_nocc_in   = op_ff.occupied;
      rsp_nh_in     = op_ff.handle;
      rsp_fv_in     = 1'b0;
      rsp_fh_in     = '0;
      if (state_ff == ST_DEQ) begin
         rsp_nocc_in = 1'b1;
         rsp_nh_in   = HANDLE_W'(entry_rd_ff);
         rsp_fv_in   = op_ff.occupied;
         rsp_fh_in   = op_ff.handle;
      end else begin
         unique case (op_ff.kind)
            K_QUERY: begin
               rsp_qempty_in = len_zero;
            end
            K_ENQ: begin
               if (store_full) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  rsp_nocc_in = 1'b0;
                  rsp_nh_in   = '0;
               end
            end
            default: begin
               rsp_qempty_in = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_count_ff <= DEPTH_COUNT;
         low_mark_ff   <= DEPTH_COUNT;
         qvalid_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_count_ff <= free_count_in;
         low_mark_ff   <= low_mark_in;
         qvalid_ff     <= qvalid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (opq_pop) begin
         op_ff <= opq_op;
      end
      if (finish) begin
         rsp_status_ff <= rsp_status_in;
         rsp_qempty_ff <= rsp_qempty_in;
         rsp_nocc_ff   <= rsp_nocc_in;
         rsp_nh_ff     <= rsp_nh_in;
         rsp_fv_ff     <= rsp_fv_in;
         rsp_fh_ff     <= rsp_fh_in;
      end
   end

   // queue tables: read on pop, written when the item completes
   always_ff @(posedge clock) begin
      if ((enq_do && len_zero) || finish_deq) begin
         head_mem[qidx] <= finish_deq ? link_rd_ff : fresh_entry;
      end
      if (opq_pop) begin
         head_rd_ff <= head_mem[opq_op.queue[QW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (enq_do) begin
         tail_mem[qidx] <= fresh_entry;
      end
      if (opq_pop) begin
         tail_rd_ff <= tail_mem[opq_op.queue[QW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (enq_do || finish_deq) begin
         len_mem[qidx] <= enq_do ? len_cur + CW'(1) : len_cur - CW'(1);
      end
      if (opq_pop) begin
         len_rd_ff    <= len_mem[opq_op.queue[QW-1:0]];
         qvalid_rd_ff <= qvalid_ff[opq_op.queue[QW-1:0]];
      end
   end

   // a new tail's own link is left stale; it is overwritten before it can matter
   always_ff @(posedge clock) begin
      if (enq_do && !len_zero) begin
         link_mem[tail_rd_ff] <= fresh_entry;
      end
      if (go_deq) begin
         link_rd_ff <= link_mem[head_rd_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (enq_do) begin
         entry_mem[fresh_entry] <= op_ff.handle[SB-1:0];
      end
      if (go_deq) begin
         entry_rd_ff <= entry_mem[head_rd_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (push_free) begin
         fstack_mem[free_count_ff[AW-1:0]] <= head_rd_ff;
      end
      if (opq_pop) begin
         fs_rd_ff <= fstack_mem[AW'(free_count_ff - CW'(1))];
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.status            = rsp_status_ff;
   assign rsp.queue_is_empty    = rsp_qempty_ff;
   assign rsp.new_slot_occupied = rsp_nocc_ff;
   assign rsp.new_slot_handle   = rsp_nh_ff;
   assign rsp.freed_valid       = rsp_fv_ff;
   assign rsp.freed_handle      = rsp_fh_ff;

   assign stat.free_count = FCOUNT_BITS'(free_count_ff);
   assign stat.low_mark   = FCOUNT_BITS'(low_mark_ff);

endmodule

// File: rtl/core/multi_queue_packet_handle_manager_unit.sv
`timescale 1ns / 1ps
`include "multi_queue_packet_handle_manager_unit_defines.svh"
// Packet handle manager: FIFO queues of handles kept in one shared linked store.
// req_bus carries one request per transfer (query empty, enqueue, dequeue) with
// the queue, the slot and the slot's current contents; rsp_bus returns one
// result per request, in request order, with status, the slot's new contents
// and any handle freed by a dequeue.
// csr_write_enable/csr_write_data set the number of active queues; write it only
// while no request is outstanding.
// The front classifies each request in the cycle it is accepted and drops it
// into a two-entry op queue. The back reads the queue tables and free stack,
// then completes queries, errors, enqueues and dequeues from an empty queue;
// a dequeue that removes a handle adds a step between the two, the read of the
// linked store at the head entry.
// A stalled rsp_bus holds its result; the back finishes reading the next item
// and then waits, and the front keeps taking requests until the op queue fills.
// Reset (synchronous) empties every queue at once through per-queue valid bits
// and refills the free stack through a low-water mark; no clearing pass is needed.
// Handles still queued at reset are dropped without being reported.
module multi_queue_packet_handle_manager_unit #(
   parameter int NUM_QUEUES  = mqph_pkg::DEF_NUM_QUEUES,
   parameter int NUM_SLOTS   = mqph_pkg::DEF_NUM_SLOTS,
   parameter int STORE_DEPTH = mqph_pkg::DEF_STORE_DEPTH,
   parameter int HANDLE_BITS = mqph_pkg::DEF_HANDLE_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   mqph_req_if.sink                         req_bus,
   mqph_rsp_if.source                       rsp_bus,
   input  logic                             csr_write_enable,
   input  logic [mqph_pkg::ACTIVE_BITS-1:0] csr_write_data
);
   import mqph_pkg::*;

   localparam logic [FCOUNT_BITS-1:0] DEPTH_LIMIT = FCOUNT_BITS'(STORE_DEPTH);

   logic [ACTIVE_BITS-1:0] active_ff;
   logic                   opq_full;
   logic                   opq_push;
   op_type                 push_op;
   logic                   opq_pop;
   op_type                 pop_op;
   logic                   opq_empty;
   back_status_type        stat;
   logic [FCOUNT_BITS-1:0] free_prev_ff;
   logic                   free_step_ok;
   logic                   rsp_error;
   logic                   rsp_freed;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_QUEUES_RESET;
      end else if (csr_write_enable) begin
         active_ff <= csr_write_data;
      end
   end

   mqph_front #(
      .NUM_QUEUES  (NUM_QUEUES),
      .NUM_SLOTS   (NUM_SLOTS),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_front (
      .req           (req_bus),
      .active_queues (active_ff),
      .opq_full      (opq_full),
      .opq_push      (opq_push),
      .opq_op        (push_op)
   );

   mqph_opq u_opq (
      .clock   (clock),
      .reset   (reset),
      .push    (opq_push),
      .push_op (push_op),
      .full    (opq_full),
      .pop     (opq_pop),
      .pop_op  (pop_op),
      .empty   (opq_empty)
   );

   mqph_back #(
      .NUM_QUEUES  (NUM_QUEUES),
      .STORE_DEPTH (STORE_DEPTH),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .opq_empty (opq_empty),
      .opq_op    (pop_op),
      .opq_pop   (opq_pop),
      .rsp       (rsp_bus),
      .stat      (stat)
   );

   always_ff @(posedge clock) begin
      free_prev_ff <= stat.free_count;
   end

   assign free_step_ok = (stat.free_count == free_prev_ff) ||
                         (stat.free_count == free_prev_ff + 1'b1) ||
                         (stat.free_count == free_prev_ff - 1'b1);
   assign rsp_error    = rsp_bus.valid && (rsp_bus.status != STATUS_OK);
   assign rsp_freed    = rsp_bus.valid && rsp_bus.freed_valid;

   `MQPH_CHECK(a_free_bound, 1'b1, stat.free_count <= DEPTH_LIMIT, "free count above store depth")
   `MQPH_CHECK(a_mark_bound, 1'b1, stat.low_mark <= stat.free_count, "low mark above free count")
   `MQPH_CHECK(a_err_no_free, rsp_error, !rsp_bus.freed_valid, "error result frees a handle")
   `MQPH_CHECK(a_freed_fills, rsp_freed, rsp_bus.new_slot_occupied, "freed without refilled slot")
   `MQPH_CHECK_NEXT(a_free_step, 1'b1, free_step_ok, "free count jumped")

endmodule
